/* rtl/cmisq_pkg.sv */
// Package for the cartridge mapper with interval IRQ and square tone channels.
// Holds the beat payload types, operation codes and register decode constants.
// No dependencies.
`default_nettype none

package cmisq_pkg;

    typedef enum logic [1:0] {
        OP_CPU_WRITE  = 2'd0,
        OP_CPU_TICK   = 2'd1,
        OP_SOUND_TICK = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic        irq_line;
        logic [3:0]  tone_a_level;
        logic [3:0]  tone_b_level;
        logic [3:0]  tone_c_level;
        logic        bank_update;
        logic [3:0]  bank_slot;
        logic [7:0]  bank_number;
        logic [1:0]  ram_mode;
        logic [1:0]  mirror_mode;
    } result_t;

    // Address bits 15:13 select the register group.
    localparam logic [2:0] GRP_COMMAND = 3'd4;
    localparam logic [2:0] GRP_PARAM   = 3'd5;
    localparam logic [2:0] GRP_SELECT  = 3'd6;
    localparam logic [2:0] GRP_SOUND   = 3'd7;

    localparam logic [3:0] CMD_WINDOW     = 4'd8;
    localparam logic [3:0] CMD_PRG_LAST   = 4'd11;
    localparam logic [3:0] CMD_MIRROR     = 4'd12;
    localparam logic [3:0] CMD_IRQ_CTRL   = 4'd13;
    localparam logic [3:0] CMD_COUNT_LOW  = 4'd14;
    localparam logic [3:0] CMD_COUNT_HIGH = 4'd15;

    localparam logic [3:0] SEL_PERIOD_LAST = 4'd5;
    localparam logic [3:0] SEL_DISABLE     = 4'd7;
    localparam logic [3:0] SEL_VOLUME_A    = 4'd8;
    localparam logic [3:0] SEL_VOLUME_C    = 4'd10;

    localparam logic [0:0] REG_CHR_BANK_MAX = 1'd0;
    localparam logic [0:0] REG_PRG_BANK_MAX = 1'd1;

    localparam int TONE_SLOTS = 3;

    function automatic logic [7:0] reduce_bank(input logic [7:0] v, input logic [7:0] max);
        reduce_bank = (v > max) ? (v & max) : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/cartridge_mapper_irq_square_sound_core.sv */
// Top level of the cartridge mapper with interval IRQ and square tone channels.
// Uses cmisq_pkg for payload types, operation codes and register decode.
// Accepted beats enter the input register; results leave the result register.
// Throughput: one beat per cycle; an input register and a result register
// form the pipeline and only a stalled, full result register holds it back.
// Reset clears all mapper, IRQ and tone state; bank maxima return to 255 and 63.
`default_nettype none

module cartridge_mapper_irq_square_sound_core #(
    parameter int TONE_CHANNELS = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire cmisq_pkg::item_t  item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output cmisq_pkg::result_t     result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [7:0]  chr_bank_max_reg;
    logic [5:0]  prg_bank_max_reg;

    logic              stage_valid_reg;
    cmisq_pkg::item_t  stage_item_reg;
    logic              result_valid_reg;
    cmisq_pkg::result_t result_reg;

    logic [3:0]  command_latch_reg, command_latch_next;
    logic [3:0]  sound_select_reg, sound_select_next;
    logic [15:0] irq_counter_reg, irq_counter_next;
    logic        irq_count_enable_reg, irq_count_enable_next;
    logic        irq_trigger_enable_reg, irq_trigger_enable_next;
    logic        irq_delay_reg, irq_delay_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [1:0]  mirror_setting_reg, mirror_setting_next;
    logic [1:0]  ram_setting_reg, ram_setting_next;

    logic [11:0] tone_period_reg  [TONE_CHANNELS];
    logic [11:0] tone_period_next [TONE_CHANNELS];
    logic [12:0] tone_timer_reg   [TONE_CHANNELS];
    logic [12:0] tone_timer_next  [TONE_CHANNELS];
    logic [4:0]  tone_phase_reg   [TONE_CHANNELS];
    logic [4:0]  tone_phase_next  [TONE_CHANNELS];
    logic [3:0]  tone_volume_reg  [TONE_CHANNELS];
    logic [3:0]  tone_volume_next [TONE_CHANNELS];
    logic        tone_disable_reg  [TONE_CHANNELS];
    logic        tone_disable_next [TONE_CHANNELS];
    logic [3:0]  tone_level_reg   [TONE_CHANNELS];
    logic [3:0]  tone_level_next  [TONE_CHANNELS];

    logic        advance;
    logic        work;
    logic        cfg_write;
    logic        upd;
    logic [3:0]  slot;
    logic [7:0]  num;
    logic [2:0]  grp;
    logic [7:0]  d;
    logic [3:0]  level_all [cmisq_pkg::TONE_SLOTS];
    cmisq_pkg::result_t result_next;

    assign advance    = !result_valid_reg || !result_stall;
    assign work       = stage_valid_reg && advance;
    assign item_stall = stage_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result     = result_reg;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign grp        = stage_item_reg.bus_address[15:13];
    assign d          = stage_item_reg.write_data;

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            cmisq_pkg::REG_CHR_BANK_MAX: prdata = {24'd0, chr_bank_max_reg};
            cmisq_pkg::REG_PRG_BANK_MAX: prdata = {26'd0, prg_bank_max_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_bank_max_reg <= 8'd255;
            prg_bank_max_reg <= 6'd63;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                cmisq_pkg::REG_CHR_BANK_MAX: chr_bank_max_reg <= pwdata[7:0];
                cmisq_pkg::REG_PRG_BANK_MAX: prg_bank_max_reg <= pwdata[5:0];
                default:                     chr_bank_max_reg <= chr_bank_max_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [1:0] sel_ch;
        logic [12:0] timer_dec;

        command_latch_next      = command_latch_reg;
        sound_select_next       = sound_select_reg;
        irq_counter_next        = irq_counter_reg;
        irq_count_enable_next   = irq_count_enable_reg;
        irq_trigger_enable_next = irq_trigger_enable_reg;
        irq_delay_next          = irq_delay_reg;
        irq_pending_next        = irq_pending_reg;
        mirror_setting_next     = mirror_setting_reg;
        ram_setting_next        = ram_setting_reg;
        tone_period_next        = tone_period_reg;
        tone_timer_next         = tone_timer_reg;
        tone_phase_next         = tone_phase_reg;
        tone_volume_next        = tone_volume_reg;
        tone_disable_next       = tone_disable_reg;
        tone_level_next         = tone_level_reg;
        upd  = 1'b0;
        slot = 4'd0;
        num  = 8'd0;
        sel_ch = 2'd0;
        timer_dec = 13'd0;

        unique case (cmisq_pkg::opcode_t'(stage_item_reg.opcode))
            cmisq_pkg::OP_CPU_WRITE:
            begin
                priority if (grp == cmisq_pkg::GRP_COMMAND)
                begin
                    command_latch_next = d[3:0];
                end
                else if (grp == cmisq_pkg::GRP_PARAM)
                begin
                    priority if (command_latch_reg < cmisq_pkg::CMD_WINDOW)
                    begin
                        upd  = 1'b1;
                        slot = command_latch_reg;
                        num  = cmisq_pkg::reduce_bank(d, chr_bank_max_reg);
                    end
                    else if (command_latch_reg == cmisq_pkg::CMD_WINDOW)
                    begin
                        ram_setting_next = d[7:6];
                        if (!d[6])
                        begin
                            upd  = 1'b1;
                            slot = cmisq_pkg::CMD_WINDOW;
                            num  = cmisq_pkg::reduce_bank({2'b00, d[5:0]},
                                                          {2'b00, prg_bank_max_reg});
                        end
                    end
                    else if (command_latch_reg <= cmisq_pkg::CMD_PRG_LAST)
                    begin
                        upd  = 1'b1;
                        slot = command_latch_reg;
                        num  = cmisq_pkg::reduce_bank(d, {2'b00, prg_bank_max_reg});
                    end
                    else if (command_latch_reg == cmisq_pkg::CMD_MIRROR)
                    begin
                        mirror_setting_next = d[1:0];
                    end
                    else if (command_latch_reg == cmisq_pkg::CMD_IRQ_CTRL)
                    begin
                        irq_trigger_enable_next = d[0];
                        irq_count_enable_next   = d[7];
                        if (!d[7])
                        begin
                            irq_pending_next = 1'b0;
                        end
                    end
                    else if (command_latch_reg == cmisq_pkg::CMD_COUNT_LOW)
                    begin
                        irq_counter_next = {irq_counter_reg[15:8], d};
                    end
                    else
                    begin
                        irq_counter_next = {d, irq_counter_reg[7:0]};
                    end
                end
                else if (grp == cmisq_pkg::GRP_SELECT)
                begin
                    sound_select_next = d[3:0];
                end
                else if (grp == cmisq_pkg::GRP_SOUND)
                begin
                    sel_ch = sound_select_reg[2:1];
                    priority if (sound_select_reg <= cmisq_pkg::SEL_PERIOD_LAST)
                    begin
                        for (int c = 0; c < TONE_CHANNELS; c++)
                        begin
                            if (sel_ch == 2'(c))
                            begin
                                if (!sound_select_reg[0])
                                    tone_period_next[c] = {tone_period_reg[c][11:8], d};
                                else
                                    tone_period_next[c] = {d[3:0], tone_period_reg[c][7:0]};
                            end
                        end
                    end
                    else if (sound_select_reg == cmisq_pkg::SEL_DISABLE)
                    begin
                        for (int c = 0; c < TONE_CHANNELS; c++)
                        begin
                            tone_disable_next[c] = d[c];
                        end
                    end
                    else if (sound_select_reg >= cmisq_pkg::SEL_VOLUME_A &&
                             sound_select_reg <= cmisq_pkg::SEL_VOLUME_C)
                    begin
                        for (int c = 0; c < TONE_CHANNELS; c++)
                        begin
                            if (sound_select_reg[1:0] == 2'(c))
                                tone_volume_next[c] = d[3:0];
                        end
                    end
                    else
                    begin
                        sel_ch = 2'd0;
                    end
                end
                else
                begin
                    sel_ch = 2'd0;
                end
            end
            cmisq_pkg::OP_CPU_TICK:
            begin
                if (irq_delay_reg)
                begin
                    irq_delay_next   = 1'b0;
                    irq_pending_next = 1'b1;
                end
                if (irq_count_enable_reg)
                begin
                    irq_counter_next = irq_counter_reg - 16'd1;
                    if (irq_counter_next == 16'd0 && irq_trigger_enable_reg)
                        irq_delay_next = 1'b1;
                end
            end
            cmisq_pkg::OP_SOUND_TICK:
            begin
                for (int c = 0; c < TONE_CHANNELS; c++)
                begin
                    timer_dec = tone_timer_reg[c] - 13'd1;
                    tone_timer_next[c] = timer_dec;
                    if (timer_dec == 13'd0)
                    begin
                        tone_phase_next[c] = tone_phase_reg[c] + 5'd1;
                        tone_timer_next[c] = {1'b0, tone_period_reg[c]} + 13'd1;
                    end
                    if (!tone_disable_reg[c] && tone_phase_next[c][4])
                        tone_level_next[c] = tone_volume_reg[c];
                    else
                        tone_level_next[c] = 4'd0;
                end
            end
            default:
            begin
                sel_ch = 2'd0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < cmisq_pkg::TONE_SLOTS; g++)
        begin : g_level
            if (g < TONE_CHANNELS)
            begin : g_used
                assign level_all[g] = tone_level_next[g];
            end
            else
            begin : g_absent
                assign level_all[g] = 4'd0;
            end
        end
    endgenerate

    always_comb
    begin
        result_next.irq_line     = irq_pending_next;
        result_next.tone_a_level = level_all[0];
        result_next.tone_b_level = level_all[1];
        result_next.tone_c_level = level_all[2];
        result_next.bank_update  = upd;
        result_next.bank_slot    = slot;
        result_next.bank_number  = num;
        result_next.ram_mode     = ram_setting_next;
        result_next.mirror_mode  = mirror_setting_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg        <= 1'b0;
            result_valid_reg       <= 1'b0;
            command_latch_reg      <= 4'd0;
            sound_select_reg       <= 4'd0;
            irq_counter_reg        <= 16'd0;
            irq_count_enable_reg   <= 1'b0;
            irq_trigger_enable_reg <= 1'b0;
            irq_delay_reg          <= 1'b0;
            irq_pending_reg        <= 1'b0;
            mirror_setting_reg     <= 2'd0;
            ram_setting_reg        <= 2'd0;
            for (int c = 0; c < TONE_CHANNELS; c++)
            begin
                tone_period_reg[c]  <= 12'd0;
                tone_timer_reg[c]   <= 13'd1;
                tone_phase_reg[c]   <= 5'd0;
                tone_volume_reg[c]  <= 4'd0;
                tone_disable_reg[c] <= 1'b0;
                tone_level_reg[c]   <= 4'd0;
            end
        end
        else
        begin
            if (!item_stall)
                stage_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= stage_valid_reg;
            if (work)
            begin
                command_latch_reg      <= command_latch_next;
                sound_select_reg       <= sound_select_next;
                irq_counter_reg        <= irq_counter_next;
                irq_count_enable_reg   <= irq_count_enable_next;
                irq_trigger_enable_reg <= irq_trigger_enable_next;
                irq_delay_reg          <= irq_delay_next;
                irq_pending_reg        <= irq_pending_next;
                mirror_setting_reg     <= mirror_setting_next;
                ram_setting_reg        <= ram_setting_next;
                tone_period_reg        <= tone_period_next;
                tone_timer_reg         <= tone_timer_next;
                tone_phase_reg         <= tone_phase_next;
                tone_volume_reg        <= tone_volume_next;
                tone_disable_reg       <= tone_disable_next;
                tone_level_reg         <= tone_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall)
            stage_item_reg <= item;
        if (work)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

/* sim/tb_cartridge_mapper_irq_square_sound_core.sv */
// Self-checking testbench for cartridge_mapper_irq_square_sound_core: CPU writes and ticks
// go in under random idling, and each result beat is checked against a cycle-free predictor.
// Depends on rtl/cmisq_pkg.sv and rtl/cartridge_mapper_irq_square_sound_core.sv.
`timescale 1ns / 1ps

class mapper_scoreboard;
    logic [7:0]  chr_limit;
    logic [5:0]  prg_limit;
    logic [3:0]  command;
    logic [3:0]  sound_sel;
    logic [15:0] irq_count;
    logic        count_en;
    logic        trigger_en;
    logic        irq_delay_q;
    logic        irq_pend;
    logic [1:0]  mirror;
    logic [1:0]  ram;
    logic [11:0] period [cmisq_pkg::TONE_SLOTS];
    logic [12:0] timer  [cmisq_pkg::TONE_SLOTS];
    logic [4:0]  phase  [cmisq_pkg::TONE_SLOTS];
    logic [3:0]  volume [cmisq_pkg::TONE_SLOTS];
    logic        mute   [cmisq_pkg::TONE_SLOTS];
    logic [3:0]  level  [cmisq_pkg::TONE_SLOTS];

    cmisq_pkg::result_t expected_results[$];
    int mismatches;
    int results_checked;
    int bank_updates_seen;
    int irq_high_seen;
    int tone_seen;

    function new();
        chr_limit = 8'd255;
        prg_limit = 6'd63;
        command = '0;
        sound_sel = '0;
        irq_count = '0;
        count_en = 1'b0;
        trigger_en = 1'b0;
        irq_delay_q = 1'b0;
        irq_pend = 1'b0;
        mirror = '0;
        ram = '0;
        for (int ch = 0; ch < cmisq_pkg::TONE_SLOTS; ch++)
        begin
            period[ch] = '0;
            timer[ch] = 13'd1;
            phase[ch] = '0;
            volume[ch] = '0;
            mute[ch] = 1'b0;
            level[ch] = '0;
        end
        mismatches = 0;
        results_checked = 0;
        bank_updates_seen = 0;
        irq_high_seen = 0;
        tone_seen = 0;
    endfunction

    function void set_limit(logic [0:0] index, logic [31:0] value);
        if (index == cmisq_pkg::REG_CHR_BANK_MAX)
            chr_limit = value[7:0];
        else
            prg_limit = value[5:0];
    endfunction

    function logic [7:0] clamp_bank(logic [7:0] v, logic [7:0] limit);
        return (v > limit) ? (v & limit) : v;
    endfunction

    function void apply_item(cmisq_pkg::item_t b);
        cmisq_pkg::result_t r;
        logic [7:0] d;
        int ch;
        r = '0;
        d = b.write_data;
        case (cmisq_pkg::opcode_t'(b.opcode))
            cmisq_pkg::OP_CPU_WRITE:
            begin
                case (b.bus_address[15:13])
                    cmisq_pkg::GRP_COMMAND: command = d[3:0];
                    cmisq_pkg::GRP_SELECT:  sound_sel = d[3:0];
                    cmisq_pkg::GRP_PARAM:
                    begin
                        if (command < cmisq_pkg::CMD_WINDOW)
                        begin
                            r.bank_update = 1'b1;
                            r.bank_slot = command;
                            r.bank_number = clamp_bank(d, chr_limit);
                        end
                        else if (command == cmisq_pkg::CMD_WINDOW)
                        begin
                            ram = d[7:6];
                            if (!d[6])
                            begin
                                r.bank_update = 1'b1;
                                r.bank_slot = cmisq_pkg::CMD_WINDOW;
                                r.bank_number = clamp_bank({2'b00, d[5:0]}, {2'b00, prg_limit});
                            end
                        end
                        else if (command <= cmisq_pkg::CMD_PRG_LAST)
                        begin
                            r.bank_update = 1'b1;
                            r.bank_slot = command;
                            r.bank_number = clamp_bank(d, {2'b00, prg_limit});
                        end
                        else if (command == cmisq_pkg::CMD_MIRROR)
                            mirror = d[1:0];
                        else if (command == cmisq_pkg::CMD_IRQ_CTRL)
                        begin
                            trigger_en = d[0];
                            count_en = d[7];
                            if (!d[7])
                                irq_pend = 1'b0;
                        end
                        else if (command == cmisq_pkg::CMD_COUNT_LOW)
                            irq_count[7:0] = d;
                        else
                            irq_count[15:8] = d;
                    end
                    cmisq_pkg::GRP_SOUND:
                    begin
                        if (sound_sel <= cmisq_pkg::SEL_PERIOD_LAST)
                        begin
                            ch = int'(sound_sel >> 1);
                            if (ch < cmisq_pkg::TONE_SLOTS)
                            begin
                                if (!sound_sel[0])
                                    period[ch][7:0] = d;
                                else
                                    period[ch][11:8] = d[3:0];
                            end
                        end
                        else if (sound_sel == cmisq_pkg::SEL_DISABLE)
                        begin
                            for (int k = 0; k < cmisq_pkg::TONE_SLOTS; k++)
                                mute[k] = d[k];
                        end
                        else if (sound_sel >= cmisq_pkg::SEL_VOLUME_A &&
                                 sound_sel <= cmisq_pkg::SEL_VOLUME_C)
                        begin
                            ch = int'(sound_sel[1:0]);
                            if (ch < cmisq_pkg::TONE_SLOTS)
                                volume[ch] = d[3:0];
                        end
                    end
                    default: ;
                endcase
            end
            cmisq_pkg::OP_CPU_TICK:
            begin
                if (irq_delay_q)
                begin
                    irq_delay_q = 1'b0;
                    irq_pend = 1'b1;
                end
                if (count_en)
                begin
                    irq_count = irq_count - 16'd1;
                    if (irq_count == 16'd0 && trigger_en)
                        irq_delay_q = 1'b1;
                end
            end
            cmisq_pkg::OP_SOUND_TICK:
            begin
                for (int k = 0; k < cmisq_pkg::TONE_SLOTS; k++)
                begin
                    level[k] = '0;
                    timer[k] = timer[k] - 13'd1;
                    if (timer[k] == 13'd0)
                    begin
                        phase[k] = phase[k] + 5'd1;
                        timer[k] = {1'b0, period[k]} + 13'd1;
                    end
                    if (!mute[k])
                        level[k] = phase[k][4] ? volume[k] : 4'd0;
                end
            end
            default: ;
        endcase
        r.irq_line = irq_pend;
        r.tone_a_level = level[0];
        r.tone_b_level = level[1];
        r.tone_c_level = level[2];
        r.ram_mode = ram;
        r.mirror_mode = mirror;
        expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(cmisq_pkg::result_t got);
        cmisq_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            $display("%0t ns: result beat with nothing expected, actual %h", $time, got);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        compare_field("irq_line", 8'(want.irq_line), 8'(got.irq_line));
        compare_field("tone_a_level", 8'(want.tone_a_level), 8'(got.tone_a_level));
        compare_field("tone_b_level", 8'(want.tone_b_level), 8'(got.tone_b_level));
        compare_field("tone_c_level", 8'(want.tone_c_level), 8'(got.tone_c_level));
        compare_field("bank_update", 8'(want.bank_update), 8'(got.bank_update));
        compare_field("bank_slot", 8'(want.bank_slot), 8'(got.bank_slot));
        compare_field("bank_number", want.bank_number, got.bank_number);
        compare_field("ram_mode", 8'(want.ram_mode), 8'(got.ram_mode));
        compare_field("mirror_mode", 8'(want.mirror_mode), 8'(got.mirror_mode));
        if (want.bank_update)
            bank_updates_seen++;
        if (want.irq_line)
            irq_high_seen++;
        if (want.tone_a_level != 0 || want.tone_b_level != 0 || want.tone_c_level != 0)
            tone_seen++;
    endfunction
endclass

module tb_cartridge_mapper_irq_square_sound_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    cmisq_pkg::item_t   beat_in = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    cmisq_pkg::result_t result_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mapper_scoreboard board;
    bit feed_gaps = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_request = 1'b0;
    int beats_sent = 0;
    int cycle_count = 0;
    int config_errors = 0;

    cartridge_mapper_irq_square_sound_core #(.TONE_CHANNELS(cmisq_pkg::TONE_SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(beat_in),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result_out),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            board.apply_item(beat_in);
        if (rst_n && result_valid && !result_stall)
            board.check_result(result_out);
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    function automatic cmisq_pkg::item_t make_beat(cmisq_pkg::opcode_t op, logic [15:0] addr,
                                                   logic [7:0] data);
        cmisq_pkg::item_t b;
        b.opcode = op;
        b.bus_address = addr;
        b.write_data = data;
        return b;
    endfunction

    function automatic logic [12:0] low13();
        return 13'($urandom);
    endfunction

    task automatic send_beat(input cmisq_pkg::item_t b);
        if (feed_gaps && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_valid <= 1'b1;
        beat_in <= b;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic cpu_write(input logic [15:0] addr, input logic [7:0] data);
        send_beat(make_beat(cmisq_pkg::OP_CPU_WRITE, addr, data));
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [31:0] value);
        logic [31:0] want;
        want = (index == cmisq_pkg::REG_CHR_BANK_MAX) ? {24'd0, value[7:0]}
                                                      : {26'd0, value[5:0]};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.set_limit(index, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            config_errors++;
            $display("%0t ns: register %0d readback, expected %0h, actual %0h",
                     $time, index, want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        send_beat(make_beat(cmisq_pkg::OP_NONE, 16'hFFFF, 8'hFF));
        cpu_write(16'h0000, 8'hFF);
        cpu_write(16'h7FFF, 8'h00);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, 8'hF0);
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'hFF);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h1FFF}, 8'h07);
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h1FFF}, 8'h00);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, {4'h0, cmisq_pkg::CMD_WINDOW});
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'h3F);
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'hC0);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, {4'h0, cmisq_pkg::CMD_PRG_LAST});
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'hFF);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, {4'hF, cmisq_pkg::CMD_MIRROR});
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'hFF);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, {4'h0, cmisq_pkg::CMD_COUNT_HIGH});
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'h00);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, {4'h0, cmisq_pkg::CMD_COUNT_LOW});
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'h02);
        cpu_write({cmisq_pkg::GRP_COMMAND, 13'h0000}, {4'h0, cmisq_pkg::CMD_IRQ_CTRL});
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'h81);
        repeat (3) send_beat(make_beat(cmisq_pkg::OP_CPU_TICK, 16'hFFFF, 8'hFF));
        cpu_write({cmisq_pkg::GRP_PARAM, 13'h0000}, 8'h00);
        cpu_write({cmisq_pkg::GRP_SELECT, 13'h0000}, {4'h0, cmisq_pkg::SEL_VOLUME_A});
        cpu_write({cmisq_pkg::GRP_SOUND, 13'h0000}, 8'hFF);
        send_beat(make_beat(cmisq_pkg::OP_SOUND_TICK, 16'h0000, 8'h00));
    endtask

    task automatic run_random(input int count);
        int target;
        int ch;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    cpu_write({cmisq_pkg::GRP_COMMAND, low13()}, 8'($urandom));
                    cpu_write({cmisq_pkg::GRP_PARAM, low13()}, 8'($urandom));
                end
                3, 4:
                begin
                    cpu_write({cmisq_pkg::GRP_SELECT, low13()}, 8'($urandom));
                    cpu_write({cmisq_pkg::GRP_SOUND, low13()}, 8'($urandom));
                end
                5:
                begin
                    cpu_write({cmisq_pkg::GRP_COMMAND, low13()},
                              {4'($urandom), cmisq_pkg::CMD_COUNT_LOW});
                    cpu_write({cmisq_pkg::GRP_PARAM, low13()}, 8'($urandom_range(0, 8)));
                    cpu_write({cmisq_pkg::GRP_COMMAND, low13()},
                              {4'($urandom), cmisq_pkg::CMD_COUNT_HIGH});
                    cpu_write({cmisq_pkg::GRP_PARAM, low13()},
                              ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
                    cpu_write({cmisq_pkg::GRP_COMMAND, low13()},
                              {4'($urandom), cmisq_pkg::CMD_IRQ_CTRL});
                    cpu_write({cmisq_pkg::GRP_PARAM, low13()},
                              8'($urandom) | (($urandom_range(0, 3) != 0) ? 8'h81 : 8'h00));
                    repeat ($urandom_range(1, 12))
                        send_beat(make_beat(cmisq_pkg::OP_CPU_TICK, 16'($urandom),
                                            8'($urandom)));
                end
                6:
                begin
                    ch = int'($urandom_range(0, cmisq_pkg::TONE_SLOTS - 1));
                    cpu_write({cmisq_pkg::GRP_SELECT, low13()}, {4'($urandom), 4'(2 * ch)});
                    cpu_write({cmisq_pkg::GRP_SOUND, low13()}, 8'($urandom_range(0, 3)));
                    cpu_write({cmisq_pkg::GRP_SELECT, low13()},
                              {4'($urandom), 4'(2 * ch + 1)});
                    cpu_write({cmisq_pkg::GRP_SOUND, low13()}, {4'($urandom), 4'h0});
                    cpu_write({cmisq_pkg::GRP_SELECT, low13()},
                              {4'($urandom), 4'(cmisq_pkg::SEL_VOLUME_A + ch)});
                    cpu_write({cmisq_pkg::GRP_SOUND, low13()}, 8'($urandom));
                    repeat ($urandom_range(16, 40))
                        send_beat(make_beat(cmisq_pkg::OP_SOUND_TICK, 16'($urandom),
                                            8'($urandom)));
                end
                7:
                begin
                    repeat ($urandom_range(1, 10))
                        send_beat(make_beat($urandom_range(0, 1) ? cmisq_pkg::OP_CPU_TICK
                                                                 : cmisq_pkg::OP_SOUND_TICK,
                                            16'($urandom), 8'($urandom)));
                end
                default:
                    send_beat(make_beat(cmisq_pkg::opcode_t'($urandom_range(0, 3)),
                                        16'($urandom), 8'($urandom)));
            endcase
        end
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(150);

        wait_drained();
        write_register(cmisq_pkg::REG_CHR_BANK_MAX, 32'd0);
        write_register(cmisq_pkg::REG_PRG_BANK_MAX, 32'd0);
        run_random(110);

        wait_drained();
        write_register(cmisq_pkg::REG_CHR_BANK_MAX, 32'($urandom_range(1, 254)));
        write_register(cmisq_pkg::REG_PRG_BANK_MAX, 32'($urandom_range(1, 62)));
        hold_request = 1'b1;
        run_random(110);

        wait_drained();
        write_register(cmisq_pkg::REG_CHR_BANK_MAX, 32'd255);
        write_register(cmisq_pkg::REG_PRG_BANK_MAX, 32'd63);
        feed_gaps = 1'b0;
        sink_gaps = 1'b0;
        run_random(170);

        wait_drained();
        repeat (4) @(posedge clk);

        $display("Checked %0d result beats over four bank limit settings,",
                 board.results_checked);
        $display("idling, a long hold-off, %0d bank updates, %0d IRQ beats, %0d tone beats.",
                 board.bank_updates_seen, board.irq_high_seen, board.tone_seen);
        if (board.mismatches == 0 && config_errors == 0 && board.expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cmisq_pkg.sv
rtl/cartridge_mapper_irq_square_sound_core.sv
sim/tb_cartridge_mapper_irq_square_sound_core.sv
